// ===== hw/rtl/pulse_train_sequencer_assert.svh =====
// Assertion macros for the pulse train sequencer checker.
`ifndef PULSE_TRAIN_SEQUENCER_ASSERT_SVH
`define PULSE_TRAIN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, reset aware.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset aware.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pts_pkg.sv =====
// Types and constants of the pulse train sequencer.
package pts_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int LEN_W = 20;
	localparam int STEP_W = 16;
	localparam int COUNT_W = 5;
	// pulse number runs 0 .. pulse_count + 1
	localparam int NUM_W = 6;
	// base + (n - 1) * step before saturation
	localparam int SUM_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ON_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ON_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd6;

	localparam logic [LEN_W-1:0] RST_SYNC_LEN = 20'd50;
	localparam logic [LEN_W-1:0] RST_BASE_ON_LEN = 20'd1300;
	localparam logic [STEP_W-1:0] RST_ON_STEP = 16'd50;
	localparam logic [LEN_W-1:0] RST_LOW_LEN = 20'd1200;
	localparam logic [COUNT_W-1:0] RST_PULSE_COUNT = 5'd17;
	localparam logic [LEN_W-1:0] RST_PAUSE_LEN = 20'd3500;
	localparam logic [LEN_W-1:0] RST_DEBOUNCE = 20'd250000;

	typedef enum logic [2:0] {
		PH_STOPPED = 3'b001,
		PH_SYNC    = 3'b010,
		PH_PULSING = 3'b100
	} phase_t;

endpackage

// ===== hw/rtl/pulse_train_sequencer.sv =====
// Pulse train sequencer: debounced buttons driving a sync and data pulse frame.
//
// Input channel (in_valid/in_ready): one word per time tick carrying the
// enable_press and mode_press falling-edge flags.
// Output channel (out_valid/out_ready): one word per tick with data_level,
// sync_level, running and reversed as they stand after that tick.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr in the
// same edge; index 7 is ignored. Write only while no tick is in flight.
// Flow: a tick word accepted into the input register moves on to the state
// and output registers when the output is free. Throughput: one word per
// cycle while out_ready is high; the next state is computed in one pass
// and lands in the state and output registers together.
// Reset: stopped, normal order, debounce counters at zero (early presses
// are ignored), registers at their default values.
// Stall: while out_ready is low the output word holds; one more word may
// enter the input register, after which in_ready drops.
module pulse_train_sequencer
	import pts_pkg::*;
#(
	parameter int TIME_WIDTH = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  enable_press,
	input  logic                  mode_press,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  data_level,
	output logic                  sync_level,
	output logic                  running,
	output logic                  reversed
);

	localparam int CW = (TIME_WIDTH > SUM_W) ? TIME_WIDTH : SUM_W;
	localparam logic [CW-1:0] TMAX_C = CW'((64'd1 << TIME_WIDTH) - 64'd1);
	localparam logic [TIME_WIDTH-1:0] TMAX_T = {TIME_WIDTH{1'b1}};

	function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [SUM_W-1:0] v);
		logic [CW-1:0] ve;
		ve = CW'(v);
		return (ve > TMAX_C) ? TIME_WIDTH'(TMAX_C) : TIME_WIDTH'(ve);
	endfunction

	function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] v);
		return (v == TMAX_T) ? v : v + TIME_WIDTH'(1);
	endfunction

	// configuration registers
	logic [LEN_W-1:0]   sync_len_q, base_on_len_q, low_len_q, pause_len_q, debounce_q;
	logic [STEP_W-1:0]  on_step_q;
	logic [COUNT_W-1:0] pulse_count_q;

	// input stage
	logic valid_s1, enable_s1, mode_s1;
	logic advance;

	// sequencer state
	logic                  run_q, rev_q, data_q, sync_q;
	phase_t                phase_q;
	logic [NUM_W-1:0]      num_q;
	logic [TIME_WIDTH-1:0] ticks_q, en_since_q, md_since_q;
	logic                  out_valid_q;

	// next state
	logic                  n_run, n_rev, n_data, n_sync, restart, done;
	phase_t                n_phase;
	logic [NUM_W-1:0]      n_num, start_num, km1;
	logic [TIME_WIDTH-1:0] n_ticks, n_en_since, n_md_since, limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_len_q    <= RST_SYNC_LEN;
			base_on_len_q <= RST_BASE_ON_LEN;
			on_step_q     <= RST_ON_STEP;
			low_len_q     <= RST_LOW_LEN;
			pulse_count_q <= RST_PULSE_COUNT;
			pause_len_q   <= RST_PAUSE_LEN;
			debounce_q    <= RST_DEBOUNCE;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_SYNC_LEN:    sync_len_q    <= cfg_wdata;
				CFG_BASE_ON_LEN: base_on_len_q <= cfg_wdata;
				CFG_ON_STEP:     on_step_q     <= cfg_wdata[STEP_W-1:0];
				CFG_LOW_LEN:     low_len_q     <= cfg_wdata;
				CFG_PULSE_COUNT: pulse_count_q <= cfg_wdata[COUNT_W-1:0];
				CFG_PAUSE_LEN:   pause_len_q   <= cfg_wdata;
				CFG_DEBOUNCE:    debounce_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			enable_s1 <= enable_press;
			mode_s1   <= mode_press;
		end
	end

	always_comb begin
		n_run      = run_q;
		n_rev      = rev_q;
		n_phase    = phase_q;
		n_num      = num_q;
		n_data     = data_q;
		n_sync     = sync_q;
		n_ticks    = ticks_q;
		restart    = 1'b0;
		done       = 1'b0;
		km1        = '0;
		limit      = sat_time(SUM_W'(debounce_q));
		n_en_since = sat_inc(en_since_q);
		n_md_since = sat_inc(md_since_q);

		if (enable_s1 && n_en_since >= limit) begin
			n_en_since = '0;
			if (n_run) begin
				n_run   = 1'b0;
				n_phase = PH_STOPPED;
				n_data  = 1'b0;
				n_sync  = 1'b0;
				n_ticks = '0;
			end else begin
				n_run   = 1'b1;
				n_phase = PH_SYNC;
				restart = 1'b1;
			end
		end
		if (mode_s1 && n_md_since >= limit) begin
			n_md_since = '0;
			n_rev      = !n_rev;
			if (n_run) begin
				n_phase = PH_SYNC;
				restart = 1'b1;
			end
		end

		start_num = n_rev ? NUM_W'(pulse_count_q) + NUM_W'(1) : '0;

		if (n_run) begin
			if (restart || ticks_q <= TIME_WIDTH'(1)) begin
				case (n_phase)
					PH_SYNC: begin
						n_ticks = sat_time(SUM_W'(sync_len_q));
						n_phase = PH_PULSING;
						n_data  = 1'b0;
						n_num   = start_num;
						n_sync  = 1'b1;
					end
					PH_PULSING: begin
						n_sync = 1'b0;
						if (n_data) begin
							n_ticks = sat_time(SUM_W'(low_len_q));
							n_data  = 1'b0;
						end else begin
							if (n_rev) begin
								if (n_num != '0) n_num = n_num - NUM_W'(1);
							end else begin
								n_num = n_num + NUM_W'(1);
							end
							km1     = (n_num != '0) ? n_num - NUM_W'(1) : '0;
							n_ticks = sat_time(SUM_W'(base_on_len_q) + SUM_W'(km1 * on_step_q));
							n_data  = 1'b1;
						end
						done = n_rev ? (n_num == '0)
							: (n_num >= NUM_W'(pulse_count_q) + NUM_W'(1));
						if (done) begin
							n_data  = 1'b0;
							n_num   = start_num;
							n_ticks = sat_time(SUM_W'(pause_len_q));
							n_phase = PH_SYNC;
						end
					end
					default: begin
						n_run   = 1'b0;
						n_phase = PH_STOPPED;
						n_data  = 1'b0;
						n_sync  = 1'b0;
						n_ticks = '0;
					end
				endcase
			end else begin
				n_ticks = ticks_q - TIME_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			rev_q       <= 1'b0;
			phase_q     <= PH_STOPPED;
			num_q       <= '0;
			data_q      <= 1'b0;
			sync_q      <= 1'b0;
			ticks_q     <= '0;
			en_since_q  <= '0;
			md_since_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			run_q       <= n_run;
			rev_q       <= n_rev;
			phase_q     <= n_phase;
			num_q       <= n_num;
			data_q      <= n_data;
			sync_q      <= n_sync;
			ticks_q     <= n_ticks;
			en_since_q  <= n_en_since;
			md_since_q  <= n_md_since;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the state registers double as the output word: they only change
	// when the previous word leaves
	assign out_valid  = out_valid_q;
	assign data_level = data_q;
	assign sync_level = sync_q;
	assign running    = run_q;
	assign reversed   = rev_q;

endmodule

// ===== hw/rtl/pts_checker.sv =====
// Port-level checker for the pulse train sequencer, bound to the top level.
`include "pulse_train_sequencer_assert.svh"

module pts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic data_level,
	input logic sync_level,
	input logic running,
	input logic reversed
);

	`PTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({data_level, sync_level, running, reversed}), "output word changed while stalled")

	`PTS_ASSERT_NOW(a_idle_low, out_valid && !running, !data_level && !sync_level, "pulse outputs high while stopped")

	`PTS_ASSERT_NOW(a_excl, out_valid, !(data_level && sync_level), "sync and data high together")

	`PTS_ASSERT_NEXT(a_one_buf, in_valid && in_ready && out_valid && !out_ready, !in_ready || out_ready, "more than one word buffered behind a stalled output")

endmodule

bind pulse_train_sequencer pts_checker u_pts_checker (.*);
